// ===== rtl/osu_pkg.sv =====
// ----------------------------------------------------------------------------
// osu_pkg
// Shared types, constants and opcode tables for the operand stack shuffle unit.
// ----------------------------------------------------------------------------
package osu_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int SLOT_BITS_DEF   = 32;
  localparam int LIMIT_W         = 7;
  localparam int OP_W            = 4;
  localparam int VALUE_W         = 32;
  localparam int STATUS_W        = 2;
  localparam int PICK_W          = 3;
  localparam int MAX_MAKE        = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [PICK_W-1:0]  PICK_PUSH   = 3'd7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 4'd0,
    OP_POP     = 4'd1,
    OP_POP2    = 4'd2,
    OP_DUP     = 4'd3,
    OP_DUP_X1  = 4'd4,
    OP_DUP_X2  = 4'd5,
    OP_DUP2    = 4'd6,
    OP_DUP2_X1 = 4'd7,
    OP_DUP2_X2 = 4'd8,
    OP_SWAP    = 4'd9
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  // slots consumed from the top
  function automatic logic [2:0] need_of(input logic [OP_W-1:0] op);
    logic [2:0] n;
    case (op)
      OP_PUSH:    n = 3'd0;
      OP_POP:     n = 3'd1;
      OP_POP2:    n = 3'd2;
      OP_DUP:     n = 3'd1;
      OP_DUP_X1:  n = 3'd2;
      OP_DUP_X2:  n = 3'd3;
      OP_DUP2:    n = 3'd2;
      OP_DUP2_X1: n = 3'd3;
      OP_DUP2_X2: n = 3'd4;
      OP_SWAP:    n = 3'd2;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  // slots written back
  function automatic logic [2:0] make_of(input logic [OP_W-1:0] op);
    logic [2:0] m;
    case (op)
      OP_PUSH:    m = 3'd1;
      OP_POP:     m = 3'd0;
      OP_POP2:    m = 3'd0;
      OP_DUP:     m = 3'd2;
      OP_DUP_X1:  m = 3'd3;
      OP_DUP_X2:  m = 3'd4;
      OP_DUP2:    m = 3'd4;
      OP_DUP2_X1: m = 3'd5;
      OP_DUP2_X2: m = 3'd6;
      OP_SWAP:    m = 3'd2;
      default:    m = 3'd0;
    endcase
    return m;
  endfunction

  // new slots bottom to top, one octal digit each, first slot in the low digit
  // digit 0..3 picks old slot a (top) .. d, PICK_PUSH picks the pushed slot
  function automatic logic [PICK_W*MAX_MAKE-1:0] pick_row(input logic [OP_W-1:0] op);
    logic [PICK_W*MAX_MAKE-1:0] r;
    case (op)
      OP_PUSH:    r = 18'o000007;
      OP_DUP:     r = 18'o000000;
      OP_DUP_X1:  r = 18'o000010;
      OP_DUP_X2:  r = 18'o000120;
      OP_DUP2:    r = 18'o000101;
      OP_DUP2_X1: r = 18'o001201;
      OP_DUP2_X2: r = 18'o012301;
      OP_SWAP:    r = 18'o000010;
      default:    r = 18'o000000;
    endcase
    return r;
  endfunction

  function automatic logic [PICK_W-1:0] pick_of(input logic [OP_W-1:0] op,
                                                input logic [2:0] idx);
    logic [PICK_W*MAX_MAKE-1:0] r;
    logic [PICK_W-1:0] p;
    r = pick_row(op);
    p = '0;
    if (idx < 3'(MAX_MAKE)) begin
      p = r[PICK_W*idx +: PICK_W];
    end
    return p;
  endfunction

endpackage

// ===== rtl/osu_ram.sv =====
// ----------------------------------------------------------------------------
// osu_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module osu_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/osu_core.sv =====
// ----------------------------------------------------------------------------
// osu_core
// Stack sequencer: checks bounds, reads the slots an operation consumes,
// writes back the rearranged slots and reports the new top and depth.
// ----------------------------------------------------------------------------
module osu_core #(
  parameter int STACK_DEPTH = osu_pkg::STACK_DEPTH_DEF,
  parameter int SLOT_BITS   = osu_pkg::SLOT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [osu_pkg::OP_W-1:0]           op,
  input  logic [osu_pkg::VALUE_W-1:0]        push_value,
  input  logic                               push_is_ref,
  input  logic [osu_pkg::LIMIT_W-1:0]        stack_limit,
  output logic                               ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0]     ram_waddr,
  output logic [SLOT_BITS:0]                 ram_wdata,
  output logic [$clog2(STACK_DEPTH)-1:0]     ram_raddr,
  input  logic [SLOT_BITS:0]                 ram_rdata,
  output logic                               done,
  output logic [osu_pkg::VALUE_W-1:0]        top_value,
  output logic                               top_is_ref,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   depth,
  output logic [osu_pkg::STATUS_W-1:0]       status
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_W = SLOT_BITS + 1;
  localparam int CMP_W  = ((PTR_W > osu_pkg::LIMIT_W) ? PTR_W : osu_pkg::LIMIT_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_WAIT  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t                    state;
  logic [2:0]                idx;
  logic [PTR_W-1:0]          top_pointer;
  logic                      cap_valid;
  logic [1:0]                cap_idx;

  logic [osu_pkg::OP_W-1:0]  op_q;
  logic [SLOT_W-1:0]         push_q;
  logic [2:0]                need_q;
  logic [2:0]                make_q;
  logic [2:0]                rd_last_q;
  logic [PTR_W-1:0]          base_q;
  logic [SLOT_W-1:0]         old [4];
  logic [SLOT_W-1:0]         top_slot;

  logic [2:0]                need_d;
  logic [2:0]                make_d;
  logic [2:0]                rd_last_d;
  logic [PTR_W-1:0]          base_d;
  logic [CMP_W-1:0]          grown;
  logic                      unused_op;
  logic                      under;
  logic                      over;
  logic                      accept;
  logic                      reject;
  logic                      go;
  logic                      finish;
  logic [PTR_W-1:0]          rd_addr;
  logic [PTR_W-1:0]          wr_addr;
  logic [osu_pkg::PICK_W-1:0] pick;
  logic [SLOT_W-1:0]         fresh;
  logic [SLOT_W-1:0]         fin_top;
  logic [PTR_W-1:0]          fin_depth;

  // decode and bounds check of the beat offered at start
  always_comb begin
    need_d    = osu_pkg::need_of(op);
    make_d    = osu_pkg::make_of(op);
    base_d    = top_pointer - PTR_W'(need_d);
    grown     = CMP_W'(top_pointer) + CMP_W'(make_d) - CMP_W'(need_d);
    unused_op = op > osu_pkg::OP_SWAP;
    under     = top_pointer < PTR_W'(need_d);
    over      = (make_d > need_d) &&
                ((grown > CMP_W'(stack_limit)) || (grown > CMP_W'(STACK_DEPTH)));
    if (make_d == 3'd0 && base_d != '0) begin
      rd_last_d = need_d;
    end else if (need_d == 3'd0) begin
      rd_last_d = 3'd0;
    end else begin
      rd_last_d = need_d - 3'd1;
    end
  end

  assign busy   = state != S_IDLE;
  assign accept = start && state == S_IDLE;
  assign reject = accept && (unused_op || under || over);
  assign go     = accept && !reject;

  // slot a is cached in top_slot, the rest come from memory
  assign rd_addr   = top_pointer - PTR_W'(1) - PTR_W'(idx);
  assign ram_raddr = rd_addr[ADDR_W-1:0];

  assign pick      = osu_pkg::pick_of(op_q, idx);
  assign fresh     = (pick == osu_pkg::PICK_PUSH) ? push_q : old[pick[1:0]];
  assign wr_addr   = base_q + PTR_W'(idx);
  assign ram_waddr = wr_addr[ADDR_W-1:0];
  assign ram_wdata = fresh;
  assign ram_we    = state == S_WRITE && make_q != 3'd0;

  assign finish    = state == S_WRITE && (make_q == 3'd0 || idx == make_q - 3'd1);
  assign fin_top   = (make_q == 3'd0) ? old[need_q[1:0]] : fresh;
  assign fin_depth = base_q + PTR_W'(make_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      top_pointer <= '0;
      cap_valid   <= 1'b0;
      done        <= 1'b0;
    end else begin
      done      <= reject || finish;
      cap_valid <= state == S_READ;
      case (state)
        S_IDLE: begin
          if (go) begin
            if (rd_last_d != 3'd0) begin
              state <= S_READ;
              idx   <= 3'd1;
            end else begin
              state <= S_WRITE;
              idx   <= 3'd0;
            end
          end
        end
        S_READ: begin
          if (idx == rd_last_q) begin
            state <= S_WAIT;
          end else begin
            idx <= idx + 3'd1;
          end
        end
        S_WAIT: begin
          state <= S_WRITE;
          idx   <= 3'd0;
        end
        S_WRITE: begin
          if (finish) begin
            state       <= S_IDLE;
            top_pointer <= fin_depth;
          end else begin
            idx <= idx + 3'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= idx[1:0];
    if (go) begin
      op_q      <= op;
      push_q    <= {push_is_ref, SLOT_BITS'(push_value)};
      need_q    <= need_d;
      make_q    <= make_d;
      rd_last_q <= rd_last_d;
      base_q    <= base_d;
      old[0]    <= top_slot;
    end
    if (cap_valid) begin
      old[cap_idx] <= ram_rdata;
    end
    if (reject) begin
      top_value  <= (top_pointer != '0) ? top_slot[osu_pkg::VALUE_W-1:0] : '0;
      top_is_ref <= (top_pointer != '0) && top_slot[SLOT_W-1];
      depth      <= top_pointer;
      if (unused_op) begin
        status <= osu_pkg::STATUS_DONE;
      end else if (under) begin
        status <= osu_pkg::STATUS_UNDERFLOW;
      end else begin
        status <= osu_pkg::STATUS_OVERFLOW;
      end
    end
    if (finish) begin
      top_slot   <= fin_top;
      top_value  <= (fin_depth != '0) ? fin_top[osu_pkg::VALUE_W-1:0] : '0;
      top_is_ref <= (fin_depth != '0) && fin_top[SLOT_W-1];
      depth      <= fin_depth;
      status     <= osu_pkg::STATUS_DONE;
    end
  end

endmodule

// ===== rtl/operand_stack_shuffle_unit.sv =====
// ----------------------------------------------------------------------------
// operand_stack_shuffle_unit
// Operand stack with push, pop and the dup/swap shuffle bytecodes.
//
// Command channel: drive op, push_value and push_is_ref with start; the beat
// is taken at a clock edge where start is high and busy is low. Each command
// gives exactly one result: done is high for one cycle with top_value,
// top_is_ref, depth and status. The receiver cannot stall and must take the
// result in that cycle. busy is low again in the cycle done is high, so the
// next command may be issued there.
// Rejected (underflow, overflow) or unused opcodes are reported without
// touching the slot memory. Otherwise the core reads R slots from memory,
// waits for the last read, then runs W write steps and reports. R is
// need - 1 (0 for push), or need for pops that expose an older slot;
// W = max(1, slots written back). The slot memory has a single write port:
// one slot a cycle is written back.
// Limit port: cfg_valid/cfg_ready write stack_limit, always ready; write only
// while no command is in flight. Reset empties the stack and sets the limit
// to 64; slot memory contents are not cleared.
// ----------------------------------------------------------------------------
module operand_stack_shuffle_unit #(
  parameter int STACK_DEPTH = osu_pkg::STACK_DEPTH_DEF,
  parameter int SLOT_BITS   = osu_pkg::SLOT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [osu_pkg::OP_W-1:0]         op,
  input  logic [osu_pkg::VALUE_W-1:0]      push_value,
  input  logic                             push_is_ref,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [osu_pkg::LIMIT_W-1:0]      cfg_data,
  output logic                             done,
  output logic [osu_pkg::VALUE_W-1:0]      top_value,
  output logic                             top_is_ref,
  output logic [$clog2(STACK_DEPTH+1)-1:0] depth,
  output logic [osu_pkg::STATUS_W-1:0]     status
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int SLOT_W = SLOT_BITS + 1;

  logic [osu_pkg::LIMIT_W-1:0] stack_limit;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [SLOT_W-1:0]           ram_wdata;
  logic [ADDR_W-1:0]           ram_raddr;
  logic [SLOT_W-1:0]           ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= osu_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stack_limit <= cfg_data;
    end
  end

  osu_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .SLOT_BITS   (SLOT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .push_value  (push_value),
    .push_is_ref (push_is_ref),
    .stack_limit (stack_limit),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .done        (done),
    .top_value   (top_value),
    .top_is_ref  (top_is_ref),
    .depth       (depth),
    .status      (status)
  );

  osu_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (STACK_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a taken command either reports right away or keeps the unit busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted command neither busy nor done");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result reported while busy");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (depth <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH)))
    else $error("depth beyond stack size");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (done && depth == '0) |-> (top_value == '0 && !top_is_ref))
    else $error("empty stack reports a top slot");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("slot memory written while idle");

endmodule
